FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int RD_COL_W  = 7;
  localparam int RD_ROW_W  = 5;
  localparam int AGE_W     = 7;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int CUR_ADR_W = 11;
  localparam int CELL_W    = 16;
  localparam int HCOUNT_W  = 8;

  localparam logic [KIND_W-1:0] KIND_PUT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RD_SCREEN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RD_HIST   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam int TAB_STEP = 8;

  typedef logic [CELL_W-1:0] cell_t;

  function automatic cell_t make_cell(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

FILE: rtl/core/tcw_if.sv
`timescale 1ns / 1ps

interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::KIND_W-1:0]    kind;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::ATTR_W-1:0]    attribute;
  logic [tcw_pkg::RD_COL_W-1:0]  read_column;
  logic [tcw_pkg::RD_ROW_W-1:0]  read_row;
  logic [tcw_pkg::AGE_W-1:0]     history_age;

  modport source (output valid, kind, char_code, attribute, read_column, read_row,
                  history_age, input ready);
  modport sink   (input valid, kind, char_code, attribute, read_column, read_row,
                  history_age, output ready);
endinterface

interface tcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::CUR_COL_W-1:0]  cursor_column;
  logic [tcw_pkg::CUR_ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::CUR_ADR_W-1:0]  cursor_address;
  logic [tcw_pkg::CELL_W-1:0]     read_cell;
  logic                           read_valid;
  logic [tcw_pkg::HCOUNT_W-1:0]   history_count;

  modport source (output valid, cursor_column, cursor_row, cursor_address, read_cell,
                  read_valid, history_count, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_address, read_cell,
                  read_valid, history_count, output ready);
endinterface

FILE: rtl/core/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  tcw_pkg::cell_t                  wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output tcw_pkg::cell_t                  rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// Read, plain put and control-character items go through the FIN state into the output registers.
// A put that scrolls first copies the top row out through the one screen read port into history.
// Clear sweeps the whole screen, one screen cell written per cycle.
// One item at a time, scroll or clear included; the next is taken while a result waits for its transfer.
// Reset: synchronous, active low; a sweep after reset zeroes the screen.

module text_console_writer #(
  parameter int COLUMNS       = 80,
  parameter int ROWS          = 25,
  parameter int HISTORY_LINES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_chan,
  tcw_out_if.source  out_chan
);

  localparam int CW          = $clog2(COLUMNS);
  localparam int RW          = $clog2(ROWS);
  localparam int HLW         = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
  localparam int HCW         = $clog2(HISTORY_LINES + 1);
  localparam int SCR_DEPTH   = ROWS * (2 ** CW);
  localparam int HIST_DEPTH  = (2 ** HLW) * (2 ** CW);
  localparam int SCR_AW      = $clog2(SCR_DEPTH);
  localparam int HIST_AW     = $clog2(HIST_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [CW-1:0]                cur_col_r, cur_col_nxt;
  logic [RW-1:0]                cur_row_r, cur_row_nxt;
  logic [RW-1:0]                top_r, top_nxt;
  logic [HLW-1:0]               hw_r, hw_nxt;
  logic [HCW-1:0]               held_r, held_nxt;
  logic [RW-1:0]                sw_row_r, sw_row_nxt;
  logic [CW-1:0]                sw_col_r, sw_col_nxt;
  logic                         sw_out_r, sw_out_nxt;
  tcw_pkg::cell_t               fill_r, fill_nxt;
  logic [CW:0]                  scnt_r, scnt_nxt;
  logic                         wv_r, wv_nxt;
  logic [CW-1:0]                wcol_r, wcol_nxt;
  logic [tcw_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                         rvalid_r, rvalid_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;

  logic [tcw_pkg::CUR_COL_W-1:0] o_col_r;
  logic [tcw_pkg::CUR_ROW_W-1:0] o_row_r;
  logic [tcw_pkg::CUR_ADR_W-1:0] o_adr_r;
  tcw_pkg::cell_t                o_cell_r;
  logic                          o_rvalid_r;
  logic [tcw_pkg::HCOUNT_W-1:0]  o_held_r;

  logic                  scr_we, scr_re;
  logic [SCR_AW-1:0]     scr_waddr, scr_raddr;
  tcw_pkg::cell_t        scr_wdata, scr_rdata;
  logic                  hist_we, hist_re;
  logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
  tcw_pkg::cell_t        hist_wdata, hist_rdata;

  logic [CW:0]           put_col;
  logic [RW:0]           put_row;
  logic                  put_we;
  logic [CW-1:0]         put_wcol;
  tcw_pkg::cell_t        put_cell;
  logic                  put_scroll;
  tcw_pkg::cell_t        blank;

  logic [7:0]            rrow8;
  logic [8:0]            rcol9;
  logic                  scr_rd_ok;
  logic                  hist_rd_ok;
  logic [13:0]           hl_t;
  logic [13:0]           hl;

  logic [15:0]           col16, row16, adr16, held16;
  tcw_pkg::cell_t        rd_cell;

  function automatic logic [RW-1:0] phys_row(logic [RW-1:0] lrow, logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, lrow} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  tcw_ram #(.DEPTH(SCR_DEPTH)) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  tcw_ram #(.DEPTH(HIST_DEPTH)) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign blank = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, in_chan.attribute);

  // character decode and cursor advance
  always_comb begin
    put_col  = {1'b0, cur_col_r};
    put_row  = {1'b0, cur_row_r};
    put_we   = 1'b0;
    put_wcol = cur_col_r;
    put_cell = tcw_pkg::make_cell(in_chan.char_code, in_chan.attribute);
    unique case (in_chan.char_code)
      tcw_pkg::CH_NEWLINE: begin
        put_col = '0;
        put_row = put_row + 1'b1;
      end
      tcw_pkg::CH_RETURN: begin
        put_col = '0;
      end
      tcw_pkg::CH_TAB: begin
        put_col = (put_col + (CW+1)'(tcw_pkg::TAB_STEP)) & ~(CW+1)'(tcw_pkg::TAB_STEP - 1);
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (cur_col_r != '0) begin
          put_col  = put_col - 1'b1;
          put_we   = 1'b1;
          put_wcol = cur_col_r - 1'b1;
          put_cell = blank;
        end
      end
      default: begin
        put_we  = 1'b1;
        put_col = put_col + 1'b1;
      end
    endcase
    if (put_col >= (CW+1)'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = (put_row >= (RW+1)'(ROWS));
  end

  // read address checks
  always_comb begin
    rrow8      = 8'(in_chan.read_row);
    rcol9      = 9'(in_chan.read_column);
    scr_rd_ok  = (rrow8 < 8'(ROWS)) && (rcol9 < 9'(COLUMNS));
    hist_rd_ok = (16'(in_chan.history_age) < 16'(held_r)) && (rcol9 < 9'(COLUMNS));
    hl_t       = 14'(hw_r) + 14'(HISTORY_LINES - 1) - 14'(in_chan.history_age);
    hl         = (hl_t >= 14'(HISTORY_LINES)) ? hl_t - 14'(HISTORY_LINES) : hl_t;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    top_nxt       = top_r;
    hw_nxt        = hw_r;
    held_nxt      = held_r;
    sw_row_nxt    = sw_row_r;
    sw_col_nxt    = sw_col_r;
    sw_out_nxt    = sw_out_r;
    fill_nxt      = fill_r;
    scnt_nxt      = scnt_r;
    wv_nxt        = 1'b0;
    wcol_nxt      = wcol_r;
    kind_nxt      = kind_r;
    rvalid_nxt    = rvalid_r;
    out_load      = 1'b0;
    scr_we        = 1'b0;
    scr_waddr     = '0;
    scr_wdata     = fill_r;
    scr_re        = 1'b0;
    scr_raddr     = '0;
    hist_we       = 1'b0;
    hist_waddr    = '0;
    hist_wdata    = scr_rdata;
    hist_re       = 1'b0;
    hist_raddr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt   = in_chan.kind;
          rvalid_nxt = 1'b0;
          state_nxt  = ST_FIN;
          unique case (in_chan.kind)
            tcw_pkg::KIND_PUT: begin
              scr_we      = put_we;
              scr_waddr   = {phys_row(cur_row_r, top_r), put_wcol};
              scr_wdata   = put_cell;
              cur_col_nxt = put_col[CW-1:0];
              if (put_scroll) begin
                cur_row_nxt = RW'(ROWS - 1);
                fill_nxt    = blank;
                scnt_nxt    = '0;
                state_nxt   = ST_SCROLL;
              end else begin
                cur_row_nxt = put_row[RW-1:0];
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              top_nxt     = '0;
              hw_nxt      = '0;
              held_nxt    = '0;
              fill_nxt    = blank;
              sw_row_nxt  = '0;
              sw_col_nxt  = '0;
              sw_out_nxt  = 1'b1;
              state_nxt   = ST_SWEEP;
            end
            tcw_pkg::KIND_RD_SCREEN: begin
              rvalid_nxt = scr_rd_ok;
              scr_re     = scr_rd_ok;
              scr_raddr  = {phys_row(rrow8[RW-1:0], top_r), rcol9[CW-1:0]};
            end
            tcw_pkg::KIND_RD_HIST: begin
              rvalid_nxt = hist_rd_ok;
              hist_re    = hist_rd_ok;
              hist_raddr = {hl[HLW-1:0], rcol9[CW-1:0]};
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        scr_we    = 1'b1;
        scr_waddr = {sw_row_r, sw_col_r};
        scr_wdata = fill_r;
        if (sw_col_r == CW'(COLUMNS - 1)) begin
          sw_col_nxt = '0;
          if (sw_row_r == RW'(ROWS - 1)) begin
            state_nxt = sw_out_r ? ST_FIN : ST_IDLE;
          end else begin
            sw_row_nxt = sw_row_r + 1'b1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end
      ST_SCROLL: begin
        // read the top row, then move each cell to history and blank it in place
        if (scnt_r < (CW+1)'(COLUMNS)) begin
          scr_re    = 1'b1;
          scr_raddr = {top_r, scnt_r[CW-1:0]};
          wv_nxt    = 1'b1;
          wcol_nxt  = scnt_r[CW-1:0];
          scnt_nxt  = scnt_r + 1'b1;
        end
        if (wv_r) begin
          hist_we    = 1'b1;
          hist_waddr = {hw_r, wcol_r};
          hist_wdata = scr_rdata;
          scr_we     = 1'b1;
          scr_waddr  = {top_r, wcol_r};
          scr_wdata  = fill_r;
        end
        if (scnt_r == (CW+1)'(COLUMNS)) begin
          top_nxt   = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
          hw_nxt    = (hw_r == HLW'(HISTORY_LINES - 1)) ? '0 : hw_r + 1'b1;
          held_nxt  = (held_r == HCW'(HISTORY_LINES)) ? held_r : held_r + 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      hw_r        <= '0;
      held_r      <= '0;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      sw_out_r    <= 1'b0;
      fill_r      <= '0;
      scnt_r      <= '0;
      wv_r        <= 1'b0;
      wcol_r      <= '0;
      kind_r      <= tcw_pkg::KIND_PUT;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      hw_r        <= hw_nxt;
      held_r      <= held_nxt;
      sw_row_r    <= sw_row_nxt;
      sw_col_r    <= sw_col_nxt;
      sw_out_r    <= sw_out_nxt;
      fill_r      <= fill_nxt;
      scnt_r      <= scnt_nxt;
      wv_r        <= wv_nxt;
      wcol_r      <= wcol_nxt;
      kind_r      <= kind_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    col16  = 16'(cur_col_r);
    row16  = 16'(cur_row_r);
    adr16  = row16 * 16'(COLUMNS) + col16;
    held16 = 16'(held_r);
    if (!rvalid_r) begin
      rd_cell = '0;
    end else if (kind_r == tcw_pkg::KIND_RD_HIST) begin
      rd_cell = hist_rdata;
    end else begin
      rd_cell = scr_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_col_r    <= col16[tcw_pkg::CUR_COL_W-1:0];
      o_row_r    <= row16[tcw_pkg::CUR_ROW_W-1:0];
      o_adr_r    <= adr16[tcw_pkg::CUR_ADR_W-1:0];
      o_cell_r   <= rd_cell;
      o_rvalid_r <= rvalid_r;
      o_held_r   <= held16[tcw_pkg::HCOUNT_W-1:0];
    end
  end

  assign in_chan.ready           = (state_r == ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.cursor_column  = o_col_r;
  assign out_chan.cursor_row     = o_row_r;
  assign out_chan.cursor_address = o_adr_r;
  assign out_chan.read_cell      = o_cell_r;
  assign out_chan.read_valid     = o_rvalid_r;
  assign out_chan.history_count  = o_held_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_col_r} < (CW+1)'(COLUMNS)) && ({1'b0, cur_row_r} < (RW+1)'(ROWS)))
    else $error("cursor outside screen");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r <= HCW'(HISTORY_LINES)) && ({1'b0, hw_r} < (HLW+1)'(HISTORY_LINES)))
    else $error("history ring pointer or count out of range");

  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.read_valid) |-> (out_chan.read_cell == '0))
    else $error("non-read result carries a cell");

  a_scroll_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) |=> ((state_r == ST_SCROLL) || (state_r == ST_FIN)))
    else $error("scroll left without finishing");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int SCR_COLS       = 80;
  localparam int SCR_ROWS       = 25;
  localparam int HIST_LINES     = 128;
  localparam int RAND_ITEMS     = 550;
  localparam int PAUSE_AT       = 300;
  localparam int LONG_HOLD_AT   = 150;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attribute;
    logic [RD_COL_W-1:0] read_column;
    logic [RD_ROW_W-1:0] read_row;
    logic [AGE_W-1:0]    history_age;
  } console_op_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_column;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_ADR_W-1:0] cursor_address;
    logic [CELL_W-1:0]    read_cell;
    logic                 read_valid;
    logic [HCOUNT_W-1:0]  history_count;
  } console_res_t;

  logic clk;
  logic rst_n;

  tcw_in_if  in_chan ();
  tcw_out_if out_chan ();

  text_console_writer #(
    .COLUMNS      (SCR_COLS),
    .ROWS         (SCR_ROWS),
    .HISTORY_LINES(HIST_LINES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  wire in_fire  = in_chan.valid && in_chan.ready;
  wire out_fire = out_chan.valid && out_chan.ready;

  // console shadow state
  logic [CELL_W-1:0] scr_mem  [0:SCR_ROWS*SCR_COLS-1];
  logic [CELL_W-1:0] hist_mem [0:HIST_LINES*SCR_COLS-1];
  int unsigned cur_col, cur_row, hist_wr, hist_held;

  console_op_t  issue_q[$];
  console_res_t expected_q[$];
  console_op_t  tx_item;

  int n_issued, n_accepted, n_results, n_errors, n_total;
  int n_scrolls, n_clears, n_valid_reads, peak_hist;
  int tx_gap, rx_hold, rx_draw, stall_cycles;

  function automatic console_res_t console_step(console_op_t o);
    console_res_t r;
    int unsigned line;
    r = '0;
    case (o.kind)
      KIND_PUT: begin
        if (o.char_code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (o.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (o.char_code == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (o.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            scr_mem[cur_row*SCR_COLS + cur_col] = {o.attribute, CH_SPACE};
          end
        end else begin
          scr_mem[cur_row*SCR_COLS + cur_col] = {o.attribute, o.char_code};
          cur_col++;
        end
        if (cur_col >= SCR_COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= SCR_ROWS) begin
          // save top line, shift up, blank bottom row
          for (int x = 0; x < SCR_COLS; x++) hist_mem[hist_wr*SCR_COLS + x] = scr_mem[x];
          hist_wr = (hist_wr + 1) % HIST_LINES;
          if (hist_held < HIST_LINES) hist_held++;
          for (int i = 0; i < (SCR_ROWS-1)*SCR_COLS; i++) scr_mem[i] = scr_mem[i + SCR_COLS];
          for (int x = 0; x < SCR_COLS; x++)
            scr_mem[(SCR_ROWS-1)*SCR_COLS + x] = {o.attribute, CH_SPACE};
          cur_row = SCR_ROWS - 1;
          n_scrolls++;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < SCR_ROWS*SCR_COLS; i++) scr_mem[i] = {o.attribute, CH_SPACE};
        cur_col   = 0;
        cur_row   = 0;
        hist_wr   = 0;
        hist_held = 0;
        n_clears++;
      end
      KIND_RD_SCREEN: begin
        if (o.read_row < SCR_ROWS && o.read_column < SCR_COLS) begin
          r.read_cell  = scr_mem[o.read_row*SCR_COLS + o.read_column];
          r.read_valid = 1'b1;
        end
      end
      default: begin
        if (o.history_age < hist_held && o.read_column < SCR_COLS) begin
          line         = (hist_wr + HIST_LINES - 1 - o.history_age) % HIST_LINES;
          r.read_cell  = hist_mem[line*SCR_COLS + o.read_column];
          r.read_valid = 1'b1;
        end
      end
    endcase
    if (r.read_valid) n_valid_reads++;
    if (hist_held > peak_hist) peak_hist = hist_held;
    r.cursor_column  = CUR_COL_W'(cur_col);
    r.cursor_row     = CUR_ROW_W'(cur_row);
    r.cursor_address = CUR_ADR_W'(cur_row*SCR_COLS + cur_col);
    r.history_count  = HCOUNT_W'(hist_held);
    return r;
  endfunction

  function automatic console_op_t op(logic [KIND_W-1:0] k, int ch, int attr,
                                     int col, int row, int age);
    console_op_t o;
    o.kind        = k;
    o.char_code   = CHAR_W'(ch);
    o.attribute   = ATTR_W'(attr);
    o.read_column = RD_COL_W'(col);
    o.read_row    = RD_ROW_W'(row);
    o.history_age = AGE_W'(age);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [CELL_W-1:0] got, logic [CELL_W-1:0] want);
    n_errors++;
    if (n_errors <= 100)
      $display("result %0d: %s got %0h expected %0h", n_results, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int pick, len, ch, r, n_rand;
    rst_n = 1'b0;
    for (int i = 0; i < SCR_ROWS*SCR_COLS; i++) scr_mem[i] = '0;
    for (int i = 0; i < HIST_LINES*SCR_COLS; i++) hist_mem[i] = '0;
    cur_col = 0; cur_row = 0; hist_wr = 0; hist_held = 0;

    issue_q.push_back(op(KIND_RD_SCREEN, 0, 0, 0, 0, 0));
    issue_q.push_back(op(KIND_RD_SCREEN, 'hFF, 'hFF, 79, 24, 127));
    issue_q.push_back(op(KIND_RD_SCREEN, 0, 0, 127, 31, 0));
    issue_q.push_back(op(KIND_RD_SCREEN, 0, 0, 80, 0, 0));
    issue_q.push_back(op(KIND_RD_HIST, 0, 0, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, 'h41, 'hFF, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, 'hFF, 0, 127, 31, 127));
    issue_q.push_back(op(KIND_PUT, 0, 'h5A, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, int'(CH_BACKSPACE), 'h11, 0, 0, 0));
    issue_q.push_back(op(KIND_RD_SCREEN, 0, 0, 2, 0, 0));
    issue_q.push_back(op(KIND_PUT, int'(CH_RETURN), 'h22, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, int'(CH_BACKSPACE), 'h33, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, int'(CH_TAB), 'h44, 0, 0, 0));
    issue_q.push_back(op(KIND_PUT, int'(CH_NEWLINE), 'h55, 0, 0, 0));
    issue_q.push_back(op(KIND_CLEAR, 0, 'hA5, 0, 0, 0));
    issue_q.push_back(op(KIND_RD_HIST, 0, 0, 0, 0, 0));
    // tabs across the full row, the last one wraps
    repeat (10) issue_q.push_back(op(KIND_PUT, int'(CH_TAB), 'h66, 0, 0, 0));
    issue_q.push_back(op(KIND_RD_SCREEN, 0, 0, 5, 0, 0));

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        issue_q.push_back(op(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        n_rand++;
      end else if (pick < 40) begin
        len = $urandom_range(1, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 4)       ch = int'(CH_NEWLINE);
          else if (r < 7)  ch = int'(CH_TAB);
          else if (r < 10) ch = int'(CH_BACKSPACE);
          else if (r < 12) ch = int'(CH_RETURN);
          else if (r < 20) ch = $urandom_range(0, 255);
          else             ch = $urandom_range(32, 126);
          issue_q.push_back(op(KIND_PUT, ch, $urandom, $urandom, $urandom, $urandom));
        end
        n_rand += len;
      end else if (pick < 60) begin
        len = $urandom_range(5, 30);
        repeat (len)
          issue_q.push_back(op(KIND_PUT, int'(CH_NEWLINE), $urandom, $urandom, $urandom,
                               $urandom));
        n_rand += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          if ($urandom_range(0, 1))
            issue_q.push_back(op(KIND_RD_SCREEN, $urandom, $urandom,
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 79),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 24),
                                 $urandom));
          else
            issue_q.push_back(op(KIND_RD_HIST, $urandom, $urandom,
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 79),
                                 $urandom,
                                 $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 127)));
        end
        n_rand += len;
      end
    end
    n_total = issue_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total || expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("%0d transfers checked: %0d scrolls, %0d clears, %0d valid cell reads",
             n_results, n_scrolls, n_clears, n_valid_reads);
    $display("history held up to %0d lines", peak_hist);
    if (n_errors == 0) $display("text_console_writer: match");
    else $display("text_console_writer: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid       <= 1'b0;
      in_chan.kind        <= '0;
      in_chan.char_code   <= '0;
      in_chan.attribute   <= '0;
      in_chan.read_column <= '0;
      in_chan.read_row    <= '0;
      in_chan.history_age <= '0;
      tx_gap              <= 0;
    end else begin
      if (in_fire) begin
        expected_q.push_back(console_step(tx_item));
        n_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          in_chan.valid <= 1'b0;
        end else if (issue_q.size() != 0 &&
                     !(n_issued == PAUSE_AT && expected_q.size() != 0)) begin
          tx_item               = issue_q.pop_front();
          in_chan.kind        <= tx_item.kind;
          in_chan.char_code   <= tx_item.char_code;
          in_chan.attribute   <= tx_item.attribute;
          in_chan.read_column <= tx_item.read_column;
          in_chan.read_row    <= tx_item.read_row;
          in_chan.history_age <= tx_item.history_age;
          in_chan.valid       <= 1'b1;
          n_issued++;
          tx_gap <= ((n_issued / 64) % 3 == 1) ? 0 : $urandom_range(0, 12);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_hold        <= 0;
    end else if (out_fire) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer, cursor_address",
                        CELL_W'(out_chan.cursor_address), '0);
      end else begin
        console_res_t want;
        want = expected_q.pop_front();
        if (out_chan.cursor_column !== want.cursor_column)
          report_mismatch("cursor_column", CELL_W'(out_chan.cursor_column),
                          CELL_W'(want.cursor_column));
        if (out_chan.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", CELL_W'(out_chan.cursor_row),
                          CELL_W'(want.cursor_row));
        if (out_chan.cursor_address !== want.cursor_address)
          report_mismatch("cursor_address", CELL_W'(out_chan.cursor_address),
                          CELL_W'(want.cursor_address));
        if (out_chan.read_cell !== want.read_cell)
          report_mismatch("read_cell", out_chan.read_cell, want.read_cell);
        if (out_chan.read_valid !== want.read_valid)
          report_mismatch("read_valid", CELL_W'(out_chan.read_valid),
                          CELL_W'(want.read_valid));
        if (out_chan.history_count !== want.history_count)
          report_mismatch("history_count", CELL_W'(out_chan.history_count),
                          CELL_W'(want.history_count));
      end
      n_results++;
      if (n_results == LONG_HOLD_AT) rx_draw = LONG_HOLD;
      else if ((n_results / 50) % 3 == 2) rx_draw = 0;
      else rx_draw = $urandom_range(0, 12);
      rx_hold        <= rx_draw;
      out_chan.ready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold        <= rx_hold - 1;
      out_chan.ready <= (rx_hold == 1);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", stall_cycles);
      $display("text_console_writer: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer.sv
tb/tb_top.sv
